>>> rtl/plc_pkg.sv
// Package with the shared constants of the piecewise linear curve evaluator.
`timescale 1ns / 1ps
`default_nettype none
package plc_pkg;
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_POS   = 2'd1;
  localparam logic [1:0] MODE_DERIV = 2'd2;
  localparam int FRAC_BITS = 16;
  // Coordinates are stored and saturated at this width.
  localparam int COORD_BITS = 32;
endpackage
`default_nettype wire

>>> rtl/plc_ram.sv
// Generic single-port RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module plc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> rtl/plc_div.sv
// Restoring divider for the segment fraction, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module plc_div #(
  parameter int NB = 33,
  parameter int QB = 17
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          go,
  input  wire logic [NB-1:0] num,
  input  wire logic [NB-1:0] den,
  output logic               done,
  output logic [QB-1:0]      quo
);
  // The quotient fits in QB bits; the numerator is shifted in MSB first.
  logic [NB-1:0]          n_sh;
  logic [NB:0]            rem;
  logic [NB-1:0]          d;
  logic [$clog2(NB+1)-1:0] cnt;
  logic                   run;
  logic [NB:0]            trial;
  logic [NB:0]            diffv;

  assign trial = {rem[NB-1:0], n_sh[NB-1]};
  assign diffv = trial - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run  <= 1'b1;
        n_sh <= num;
        d    <= den;
        rem  <= '0;
        quo  <= '0;
        cnt  <= ($clog2(NB+1))'(NB);
      end else if (run) begin
        n_sh <= {n_sh[NB-2:0], 1'b0};
        if (!diffv[NB]) begin
          rem <= diffv;
          quo <= {quo[QB-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[QB-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == 1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/piecewise_linear_curve_eval_core.sv
// Top level of the piecewise linear curve evaluator.
// Usage: pulse start with mode and the payload while busy is low. A load
// item (mode 0) writes x, y, z and the parameter into slot load_index and
// gives no result; busy is high for one cycle, after which the next item
// can be taken. A query (mode 1 position, mode 2 derivative) scans segments
// from the first and answers with one result, marked by done for exactly
// one cycle. Mode 3 is dropped silently and busy stays low.
// The scan visits S_SCAN and S_CHK for each stored point, since each
// parameter comes from a RAM with a registered read. A position query that
// hits a segment then fetches the segment ends, runs the restoring division
// of the fraction and works each axis on the shared multiplier in two steps
// (S_MUL, S_ACC); a derivative query skips the division, and a query that
// finds nothing goes straight to the result. The worst case is a position
// query on the last segment of a full store.
// busy is low in the cycle that shows the result, so the next item can be
// taken at the same edge as the result.
// The user must write point_count through cfg_we/cfg_data only while the
// block is idle; the block itself does not enforce this.
// Reset clears the sequencer and point_count; the point store is not
// cleared, and an unwritten entry that a query reaches reads as anything.
// The receiver cannot stall: each result is shown once and must be taken.
`timescale 1ns / 1ps
`default_nettype none
module piecewise_linear_curve_eval_core #(
  parameter int MAX_POINTS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_data,
  input  wire logic [1:0]  mode,
  input  wire logic [9:0]  load_index,
  input  wire logic signed [31:0] coord_x,
  input  wire logic signed [31:0] coord_y,
  input  wire logic signed [31:0] coord_z,
  input  wire logic signed [31:0] param_value,
  output logic             done,
  output logic             found,
  output logic [9:0]       segment,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [31:0] query_param
);
  import plc_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = COORD_BITS;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_LOAD  = 10'b0000000010,
    S_SCAN  = 10'b0000000100,
    S_CHK   = 10'b0000001000,
    S_FETCH = 10'b0000010000,
    S_HOLD  = 10'b0000100000,
    S_DIV   = 10'b0001000000,
    S_MUL   = 10'b0010000000,
    S_ACC   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state;
  logic [10:0] point_count;
  logic [1:0]  qmode;
  logic signed [31:0] t;
  logic [16:0] n_use;
  logic [16:0] idx;
  logic signed [31:0] p_prev;
  logic        have_prev;
  logic [AW-1:0] seg;
  logic        hit;
  logic [1:0]  axis;

  // RAM signals
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [CW-1:0] rx, ry, rz;
  logic [31:0]   rp;
  logic signed [CW-1:0] bx, by, bz;
  logic signed [31:0] pb, pe;

  always_comb begin
    n_use = (17'(point_count) > 17'(MAX_POINTS)) ? 17'(MAX_POINTS) : 17'(point_count);
  end

  assign busy = (state != S_IDLE);

  // The cycle after a hit the RAMs show the segment's end point, read at the
  // scan address; the start point is read at seg during the fetch.
  always_comb begin
    ram_we   = (state == S_IDLE) && start && (mode == MODE_LOAD)
               && (32'(load_index) < 32'(MAX_POINTS));
    ram_addr = AW'(load_index);
    if (state == S_SCAN || state == S_CHK) begin
      ram_addr = idx[AW-1:0];
    end else if (state == S_IDLE) begin
      ram_addr = AW'(load_index);
    end else begin
      ram_addr = seg;
    end
  end

  plc_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_rx (.clk, .we(ram_we), .addr(ram_addr),
    .wdata(CW'(coord_x)), .rdata(rx));
  plc_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_ry (.clk, .we(ram_we), .addr(ram_addr),
    .wdata(CW'(coord_y)), .rdata(ry));
  plc_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_rz (.clk, .we(ram_we), .addr(ram_addr),
    .wdata(CW'(coord_z)), .rdata(rz));
  plc_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_rp (.clk, .we(ram_we), .addr(ram_addr),
    .wdata(param_value), .rdata(rp));

  // Fraction divider: (t - tmin) << 16 over the span, both fit 33 bits unsigned.
  // The quotient never exceeds 65536 when the span is non-zero.
  logic        div_go, div_done;
  logic [48:0] div_num, div_den;
  logic [16:0] div_q;
  logic [16:0] frac;
  logic [32:0] off, span;
  assign off     = 33'($signed(t) - $signed(pb));
  assign span    = 33'($signed(pe) - $signed(pb));
  assign div_num = {off, 16'd0};
  assign div_den = {16'd0, span};
  plc_div #(.NB(49), .QB(17)) u_div (.clk, .rst, .go(div_go), .num(div_num),
    .den(div_den), .done(div_done), .quo(div_q));

  // Shared multiplier for the three axes: difference times fraction.
  logic signed [CW:0]    dsel;
  logic signed [CW+18:0] prod;
  logic signed [CW+18:0] rnd;
  logic signed [CW+2:0]  val;
  logic signed [CW-1:0]  bsel;
  logic signed [CW-1:0]  esel;
  logic signed [CW-1:0]  ex, ey, ez;
  logic signed [CW+2:0]  sat_in;
  logic signed [CW-1:0]  sat_out;

  always_comb begin
    case (axis)
      2'd0:    begin bsel = bx; esel = ex; end
      2'd1:    begin bsel = by; esel = ey; end
      default: begin bsel = bz; esel = ez; end
    endcase
    dsel = (CW+1)'(esel) - (CW+1)'(bsel);
  end

  function automatic logic signed [CW-1:0] sat(input logic signed [CW+2:0] v);
    logic signed [CW+2:0] hi;
    logic signed [CW+2:0] lo;
    hi = (CW+3)'((64'sd1 <<< (CW-1)) - 1);
    lo = -hi - 1;
    if (v > hi) return hi[CW-1:0];
    if (v < lo) return lo[CW-1:0];
    return v[CW-1:0];
  endfunction

  assign rnd    = prod + (CW+19)'(32768);
  assign val    = (CW+3)'(bsel) + (CW+3)'(rnd >>> FRAC_BITS);
  assign sat_in = (qmode == MODE_POS) ? val : (CW+3)'(dsel);
  assign sat_out = sat(sat_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point_count <= '0;
      done        <= 1'b0;
      div_go      <= 1'b0;
    end else begin
      done   <= 1'b0;
      div_go <= 1'b0;
      if (cfg_we) point_count <= cfg_data;
      case (state)
        S_IDLE: begin
          if (start) begin
            qmode <= mode;
            t     <= param_value;
            idx   <= '0;
            have_prev <= 1'b0;
            hit   <= 1'b0;
            seg   <= '0;
            if (mode == MODE_LOAD) state <= S_LOAD;
            else if (mode == MODE_POS || mode == MODE_DERIV) state <= S_SCAN;
          end
        end
        S_LOAD: state <= S_IDLE;
        S_SCAN: begin
          // Address idx presented; data next cycle.
          if (idx >= n_use) state <= S_OUT;
          else state <= S_CHK;
        end
        S_CHK: begin
          if (have_prev && $signed(t) >= $signed(p_prev) && $signed(t) <= $signed(rp)) begin
            hit   <= 1'b1;
            seg   <= AW'(idx - 1'b1);
            state <= S_FETCH;
          end else begin
            p_prev    <= rp;
            have_prev <= 1'b1;
            idx       <= idx + 1'b1;
            state     <= S_SCAN;
          end
        end
        S_FETCH: begin
          ex <= rx; ey <= ry; ez <= rz; pe <= rp;
          state <= S_HOLD;
        end
        S_HOLD: begin
          bx <= rx; by <= ry; bz <= rz; pb <= rp;
          axis <= 2'd0;
          if (qmode == MODE_POS) begin
            div_go <= 1'b1;
            state  <= S_DIV;
          end else begin
            frac  <= '0;
            state <= S_MUL;
          end
        end
        S_DIV: begin
          if (div_done) begin
            frac  <= (span == '0) ? 17'd0 : div_q;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= (CW+19)'(dsel) * $signed({2'b00, frac});
          state <= S_ACC;
        end
        S_ACC: begin
          case (axis)
            2'd0:    out_x <= 32'(sat_out);
            2'd1:    out_y <= 32'(sat_out);
            default: out_z <= 32'(sat_out);
          endcase
          if (axis == 2'd2) state <= S_OUT;
          else begin
            axis  <= axis + 1'b1;
            state <= S_MUL;
          end
        end
        S_OUT: begin
          done        <= 1'b1;
          found       <= hit;
          segment     <= hit ? 10'(seg) : 10'd0;
          query_param <= t;
          if (!hit) begin
            out_x <= '0; out_y <= '0; out_z <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/plc_checker.sv
// Port-level checker for the curve evaluator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module plc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic [1:0] mode,
  input wire logic done,
  input wire logic found,
  input wire logic [9:0] segment,
  input wire logic signed [31:0] out_x
);
  import plc_pkg::*;

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  a_busy_done: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("busy while done");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !found |-> segment == 10'd0 && out_x == 32'sd0)
    else $error("miss not zero");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (mode == MODE_LOAD || mode == MODE_POS || mode == MODE_DERIV)
    |=> busy)
    else $error("no busy");
endmodule
bind piecewise_linear_curve_eval_core plc_checker u_chk (.clk, .rst, .start, .busy,
  .mode, .done, .found, .segment, .out_x);
`default_nettype wire
